[src/blpw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package blpw_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF    = 1024;
  localparam int COORD_FRAC_DEF = 14;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int DIM_W   = 11;
  localparam int COLOR_W = 32;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  // Depth of the queue between the front and back
  localparam int Q_DEPTH = 2;

  // Register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd240;

  // Item function codes
  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  // Register indexes (word address bit 2)
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[src/blpw_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module blpw_front #(
  parameter int MAX_DIM         = blpw_pkg::MAX_DIM_DEF,
  parameter int COORD_FRAC_BITS = blpw_pkg::COORD_FRAC_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    func,
  input  logic signed [blpw_pkg::COORD_W-1:0]     x_start,
  input  logic signed [blpw_pkg::COORD_W-1:0]     y_start,
  input  logic signed [blpw_pkg::COORD_W-1:0]     x_end,
  input  logic signed [blpw_pkg::COORD_W-1:0]     y_end,
  input  logic        [blpw_pkg::COLOR_W-1:0]     line_color,
  input  logic        [blpw_pkg::DIM_W-1:0]       frame_width,
  input  logic        [blpw_pkg::DIM_W-1:0]       frame_height,
  input  blpw_pkg::q_stat_t                       q_stat,
  output logic                                    q_push,
  output logic [1+4*$clog2(MAX_DIM)+blpw_pkg::COLOR_W-1:0] q_data
);
  import blpw_pkg::*;

  localparam int PIX_W  = $clog2(MAX_DIM);
  // Signed width of n + 1.0
  localparam int S_W    = ((COORD_FRAC_BITS + 1 > COORD_W) ? COORD_FRAC_BITS + 1 : COORD_W) + 1;
  localparam int HALF_W = DIM_W - 1;
  localparam int PROD_W = S_W - 1 + HALF_W;
  localparam int HI_W   = PROD_W - COORD_FRAC_BITS;
  localparam int CMP_W  = (HI_W > PIX_W) ? HI_W : PIX_W;
  localparam int LIM_W  = (DIM_W > PIX_W + 1) ? DIM_W : PIX_W + 1;
  localparam logic [S_W-1:0] ONE = {{(S_W-1){1'b0}}, 1'b1} << COORD_FRAC_BITS;

  // n + 1.0, floored at zero
  function automatic logic [S_W-2:0] shift_pos(input logic [COORD_W-1:0] n);
    logic [S_W-1:0] s;
    s = {{(S_W-COORD_W){n[COORD_W-1]}}, n} + ONE;
    shift_pos = s[S_W-1] ? '0 : s[S_W-2:0];
  endfunction

  // Largest pixel index on an axis: min(dim, MAX_DIM) - 1, never below zero
  function automatic logic [PIX_W-1:0] dim_lim(input logic [DIM_W-1:0] dim);
    logic [LIM_W-1:0] d;
    logic [LIM_W-1:0] m;
    d = LIM_W'(dim);
    m = LIM_W'(MAX_DIM);
    if (d > m) d = m;
    dim_lim = (d == '0) ? '0 : PIX_W'(d - 1'b1);
  endfunction

  // Drop the fraction and saturate at the axis limit
  function automatic logic [PIX_W-1:0] clamp_px(input logic [PROD_W-1:0] p,
                                                input logic [PIX_W-1:0]  lim);
    logic [CMP_W-1:0] hi;
    hi = CMP_W'(p[PROD_W-1:COORD_FRAC_BITS]);
    clamp_px = (hi > CMP_W'(lim)) ? lim : PIX_W'(hi);
  endfunction

  logic                f_valid;
  func_t               f_func;
  logic [PROD_W-1:0]   f_prod_x1, f_prod_y1, f_prod_x2, f_prod_y2;
  logic [PIX_W-1:0]    f_lim_x, f_lim_y;
  logic [COLOR_W-1:0]  f_color;
  logic                accept;
  logic [HALF_W-1:0]   half_w, half_h;

  assign in_ready = !f_valid || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = f_valid && !q_stat.full;
  assign half_w   = frame_width[DIM_W-1:1];
  assign half_h   = frame_height[DIM_W-1:1];

  // Stage register: scaled coordinates, one multiply per endpoint axis
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_func    <= func_t'(func);
      f_prod_x1 <= PROD_W'(shift_pos(x_start)) * PROD_W'(half_w);
      f_prod_y1 <= PROD_W'(shift_pos(y_start)) * PROD_W'(half_h);
      f_prod_x2 <= PROD_W'(shift_pos(x_end)) * PROD_W'(half_w);
      f_prod_y2 <= PROD_W'(shift_pos(y_end)) * PROD_W'(half_h);
      f_lim_x   <= dim_lim(frame_width);
      f_lim_y   <= dim_lim(frame_height);
      f_color   <= line_color;
    end
  end

  // Classified item into the queue
  assign q_data = {f_func,
                   clamp_px(f_prod_x1, f_lim_x), clamp_px(f_prod_y1, f_lim_y),
                   clamp_px(f_prod_x2, f_lim_x), clamp_px(f_prod_y2, f_lim_y),
                   f_color};

endmodule

`default_nettype wire

[src/blpw_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module blpw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = blpw_pkg::Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              pop,
  output logic [WIDTH-1:0]  rdata,
  output blpw_pkg::q_stat_t stat
);
  import blpw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = entry[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= next_ptr(wr_ptr);
      if (pop)  rd_ptr <= next_ptr(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) entry[wr_ptr] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full || pop)
    else $error("item written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("item read from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("fill count did not follow a write");

endmodule

`default_nettype wire

[src/blpw_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module blpw_back #(
  parameter int MAX_DIM = blpw_pkg::MAX_DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  blpw_pkg::q_stat_t                      q_stat,
  input  logic [1+4*$clog2(MAX_DIM)+blpw_pkg::COLOR_W-1:0] q_data,
  output logic                                   q_pop,
  input  logic [blpw_pkg::DIM_W-1:0]             frame_width,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [$clog2(MAX_DIM)-1:0]             pixel_x,
  output logic [$clog2(MAX_DIM)-1:0]             pixel_y,
  output logic [2*$clog2(MAX_DIM)-1:0]           pixel_addr,
  output logic [blpw_pkg::COLOR_W-1:0]           pixel_color,
  output logic                                   last_pixel
);
  import blpw_pkg::*;

  localparam int PIX_W  = $clog2(MAX_DIM);
  localparam int ITEM_W = 1 + 4*PIX_W + COLOR_W;
  localparam int ERR_W  = PIX_W + 2;
  localparam int E2_W   = ERR_W + 1;
  localparam int MUL_W  = PIX_W + DIM_W;
  localparam int SUM_W  = ((MUL_W > 2*PIX_W) ? MUL_W : 2*PIX_W) + 1;

  // Head item fields
  func_t              hd_func;
  logic [PIX_W-1:0]   hd_x1, hd_y1, hd_x2, hd_y2;
  logic [COLOR_W-1:0] hd_color;

  assign hd_func  = func_t'(q_data[ITEM_W-1]);
  assign hd_x1    = q_data[COLOR_W+4*PIX_W-1 -: PIX_W];
  assign hd_y1    = q_data[COLOR_W+3*PIX_W-1 -: PIX_W];
  assign hd_x2    = q_data[COLOR_W+2*PIX_W-1 -: PIX_W];
  assign hd_y2    = q_data[COLOR_W+PIX_W-1 -: PIX_W];
  assign hd_color = q_data[COLOR_W-1:0];

  // Line state
  logic                    line_active;
  logic [PIX_W-1:0]        cur_col, cur_row, end_col, end_row;
  logic [PIX_W-1:0]        abs_dx, abs_dy;
  logic signed [ERR_W-1:0] err_term;
  logic                    step_x_negative, step_y_negative;
  logic [COLOR_W-1:0]      held_color;

  logic slot_free, is_start, is_adv, at_end;

  assign slot_free = !out_valid || out_ready;
  assign q_pop     = !q_stat.empty && slot_free;
  assign is_start  = q_pop && (hd_func == FUNC_START);
  assign is_adv    = q_pop && (hd_func == FUNC_ADVANCE) && line_active;
  assign at_end    = (cur_col == end_col) && (cur_row == end_row);

  // Line setup from the mapped endpoints
  logic [PIX_W-1:0]        dx_start, dy_start;
  logic signed [ERR_W-1:0] err_start;

  assign dx_start  = (hd_x2 > hd_x1) ? hd_x2 - hd_x1 : hd_x1 - hd_x2;
  assign dy_start  = (hd_y2 > hd_y1) ? hd_y2 - hd_y1 : hd_y1 - hd_y2;
  assign err_start = $signed({2'b00, dx_start}) - $signed({2'b00, dy_start});

  // One Bresenham step
  logic signed [E2_W-1:0] e2, dx_e, dy_e, err_sum;
  logic                   step_x, step_y;

  assign e2      = {err_term, 1'b0};
  assign dx_e    = $signed({{(E2_W-PIX_W){1'b0}}, abs_dx});
  assign dy_e    = $signed({{(E2_W-PIX_W){1'b0}}, abs_dy});
  assign step_x  = e2 > -dy_e;
  assign step_y  = e2 < dx_e;
  assign err_sum = {err_term[ERR_W-1], err_term}
                   + (step_y ? dx_e : '0) - (step_x ? dy_e : '0);

  // Linear address of the current pixel
  logic [SUM_W-1:0] addr_full;

  assign addr_full = SUM_W'(cur_row) * SUM_W'(frame_width) + SUM_W'(cur_col);

  // Line state, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (is_start) begin
        line_active <= 1'b1;
      end else if (is_adv && at_end) begin
        line_active <= 1'b0;
      end
      if (is_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (is_start) begin
      cur_col         <= hd_x1;
      cur_row         <= hd_y1;
      end_col         <= hd_x2;
      end_row         <= hd_y2;
      abs_dx          <= dx_start;
      abs_dy          <= dy_start;
      step_x_negative <= !(hd_x1 < hd_x2);
      step_y_negative <= !(hd_y1 < hd_y2);
      err_term        <= err_start;
      held_color      <= hd_color;
    end else if (is_adv && !at_end) begin
      if (step_x) cur_col <= step_x_negative ? cur_col - 1'b1 : cur_col + 1'b1;
      if (step_y) cur_row <= step_y_negative ? cur_row - 1'b1 : cur_row + 1'b1;
      err_term <= err_sum[ERR_W-1:0];
    end

    if (is_adv) begin
      pixel_x     <= cur_col;
      pixel_y     <= cur_row;
      pixel_addr  <= addr_full[2*PIX_W-1:0];
      pixel_color <= held_color;
      last_pixel  <= at_end;
    end
  end

  a_end_only_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(line_active) && !$past(rst) |-> $past(is_adv && at_end))
    else $error("line ended without emitting its end pixel");

  a_adv_emits: assert property (@(posedge clk) disable iff (rst)
    is_adv |=> out_valid && last_pixel == $past(at_end))
    else $error("advance on an active line produced no pixel");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_pop)
    else $error("queue popped while the output register was held");

endmodule

`default_nettype wire

[src/bresenham_line_pixel_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line walker. A start item (func = 0) maps both Q1.14 endpoints to
// screen pixels against frame_width/frame_height and latches the color; it
// emits nothing. Each advance item (func = 1) emits the current pixel (x, y,
// y*frame_width+x, color, last flag) and steps; advances with no active line
// emit nothing. Sustained rate is one item per clock while out_ready holds high:
// the front scales the endpoints in one registered multiply stage, a two-entry
// queue decouples it from the back, and the back runs one error step and one
// address multiply per clock into the output register. An advance item passes
// the front register and the queue first. Write frame_width (offset 0x0)
// and frame_height (0x4) only while no line items are in flight.
module bresenham_line_pixel_walker #(
  parameter int MAX_DIM         = blpw_pkg::MAX_DIM_DEF,
  parameter int COORD_FRAC_BITS = blpw_pkg::COORD_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [blpw_pkg::PADDR_W-1:0]        paddr,
  input  logic [blpw_pkg::APB_W-1:0]          pwdata,
  output logic [blpw_pkg::APB_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic signed [blpw_pkg::COORD_W-1:0] x_start,
  input  logic signed [blpw_pkg::COORD_W-1:0] y_start,
  input  logic signed [blpw_pkg::COORD_W-1:0] x_end,
  input  logic signed [blpw_pkg::COORD_W-1:0] y_end,
  input  logic [blpw_pkg::COLOR_W-1:0]        line_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [$clog2(MAX_DIM)-1:0]          pixel_x,
  output logic [$clog2(MAX_DIM)-1:0]          pixel_y,
  output logic [2*$clog2(MAX_DIM)-1:0]        pixel_addr,
  output logic [blpw_pkg::COLOR_W-1:0]        pixel_color,
  output logic                                last_pixel
);
  import blpw_pkg::*;

  localparam int PIX_W  = $clog2(MAX_DIM);
  localparam int ITEM_W = 1 + 4*PIX_W + COLOR_W;

  // Configuration registers
  logic [DIM_W-1:0] frame_width, frame_height;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  q_stat_t           q_stat;
  logic              q_push, q_pop;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  blpw_front #(
    .MAX_DIM         (MAX_DIM),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .line_color   (line_color),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  blpw_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  blpw_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .frame_width (frame_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_addr  (pixel_addr),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule

`default_nettype wire
